// ----- sv/yiq_luma_brightness_adjust_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef YIQ_LUMA_BRIGHTNESS_ADJUST_MACROS_SVH
`define YIQ_LUMA_BRIGHTNESS_ADJUST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define YLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- sv/yla_pkg.sv -----
`timescale 1ns / 1ps

package yla_pkg;

  localparam int LEVEL_BITS = 3;

  typedef logic signed [LEVEL_BITS-1:0] level_t;

  localparam level_t LVL_UP2 = 3'sd2;
  localparam level_t LVL_UP1 = 3'sd1;
  localparam level_t LVL_DN1 = -3'sd1;
  localparam level_t LVL_DN2 = -3'sd2;
  localparam level_t LVL_DN3 = -3'sd3;

  // Matrix entries and luma fractions in millionths.
  localparam int FWD_MICRO [3][3] = '{
    '{299000, 587000, 114000},
    '{595716, -274453, -321263},
    '{211456, -522591, 311135}
  };
  localparam int INV_MICRO [3][2] = '{
    '{956300, 621000},
    '{-272100, -647400},
    '{-1107000, 1704600}
  };
  localparam int K_MICRO_HI  = 800000;
  localparam int K_MICRO_LO  = 200000;
  localparam int K_MICRO_MAX = 950000;

  // Rounds a millionths constant to frac fraction bits, halves away from zero.
  function automatic longint quant(input int micro, input int frac);
    longint mag;
    longint q;
    mag = (micro < 0) ? -longint'(micro) : longint'(micro);
    q = (mag * (longint'(1) << frac) + 64'sd500000) / 64'sd1000000;
    return (micro < 0) ? -q : q;
  endfunction

endpackage

// ----- sv/yla_if.sv -----
`timescale 1ns / 1ps

interface yla_in_if #(
  parameter int CHANNEL_BITS = 8
) ();
  logic                        valid;
  logic                        ready;
  logic [CHANNEL_BITS-1:0]     red_in;
  logic [CHANNEL_BITS-1:0]     green_in;
  logic [CHANNEL_BITS-1:0]     blue_in;
  yla_pkg::level_t             level;

  modport source (output valid, red_in, green_in, blue_in, level, input ready);
  modport sink (input valid, red_in, green_in, blue_in, level, output ready);
endinterface

interface yla_out_if #(
  parameter int CHANNEL_BITS = 8
) ();
  logic                        valid;
  logic                        ready;
  logic [CHANNEL_BITS-1:0]     red_out;
  logic [CHANNEL_BITS-1:0]     green_out;
  logic [CHANNEL_BITS-1:0]     blue_out;
  logic                        clipped;

  modport source (output valid, red_out, green_out, blue_out, clipped, input ready);
  modport sink (input valid, red_out, green_out, blue_out, clipped, output ready);
endinterface

// ----- sv/yla_chan_out.sv -----
`timescale 1ns / 1ps

module yla_chan_out #(
  parameter int CHANNEL_BITS   = 8,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic signed [CHANNEL_BITS+COEF_FRAC_BITS+2:0]   y_i,
  input  logic signed [CHANNEL_BITS+2*COEF_FRAC_BITS+5:0] p_i_i,
  input  logic signed [CHANNEL_BITS+2*COEF_FRAC_BITS+5:0] p_q_i,
  output logic        [CHANNEL_BITS-1:0]                  ch_o,
  output logic                                            clip_o
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int PB = CHANNEL_BITS + 2 * F + 6;
  localparam int AW = PB + 2;
  localparam int VW = AW - 2 * F;

  localparam logic signed [AW-1:0] RND    = AW'(longint'(1) << (2 * F - 1));
  localparam logic signed [VW-1:0] CH_MAX = VW'((longint'(1) << CHANNEL_BITS) - 1);

  logic signed [AW-1:0] acc;
  logic signed [VW-1:0] val;

  assign acc = (AW'(y_i) <<< F) + AW'(p_i_i) + AW'(p_q_i) + RND;
  assign val = VW'(acc >>> (2 * F));

  always_comb begin
    priority if (val[VW-1]) begin
      ch_o   = '0;
      clip_o = 1'b1;
    end else if (val > CH_MAX) begin
      ch_o   = '1;
      clip_o = 1'b1;
    end else begin
      ch_o   = val[CHANNEL_BITS-1:0];
      clip_o = 1'b0;
    end
  end

endmodule

// ----- sv/yiq_luma_brightness_adjust.sv -----
`timescale 1ns / 1ps

// YIQ luma brightness adjuster.
// Each request on pix_i carries one RGB pixel and a brightness level from -3
// to 2. The pixel is converted to YIQ, its luma moves toward or away from full
// scale by a level-chosen fraction of its gap to full scale, and the triple is
// converted back to RGB. Each channel of the request on pix_o is saturated
// to its range, and clipped reports whether any channel was saturated.
// Both channels use valid and ready; a request moves on a clock edge at
// which both are high.
// The datapath has five register stages: forward products, YIQ sums, luma
// delta product, adjusted luma with back-conversion products, and the output
// register, in that order. One pixel is taken every cycle unless a stall on
// pix_o has filled every stage. Each stage advances on its own, so a stall
// on pix_o fills empty stages first and drops or repeats nothing.
// Reset empties all stages; pix_i is ready as soon as stage one is free.
module yiq_luma_brightness_adjust #(
  parameter int CHANNEL_BITS   = 8,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  yla_in_if.sink       pix_i,
  yla_out_if.source    pix_o
);

  localparam int CB = CHANNEL_BITS;
  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 3;
  localparam int PW = CW + CB + 1;
  localparam int YW = CB + F + 3;
  localparam int MW = YW + CW;
  localparam int PB = YW + CW;
  localparam int NS = 5;

  localparam logic signed [YW-1:0] ONE    = YW'(((longint'(1) << CB) - 1) << F);
  localparam logic signed [MW-1:0] HALF_F = MW'(longint'(1) << (F - 1));
  localparam logic signed [CW-1:0] K_HI   = CW'(yla_pkg::quant(yla_pkg::K_MICRO_HI, F));
  localparam logic signed [CW-1:0] K_LO   = CW'(yla_pkg::quant(yla_pkg::K_MICRO_LO, F));
  localparam logic signed [CW-1:0] K_MAX  = CW'(yla_pkg::quant(yla_pkg::K_MICRO_MAX, F));

  logic signed [CW-1:0] fwd_c [3][3];
  logic signed [CW-1:0] inv_c [3][2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        fwd_c[i][j] = CW'(yla_pkg::quant(yla_pkg::FWD_MICRO[i][j], F));
      end
      for (int j = 0; j < 2; j++) begin
        inv_c[i][j] = CW'(yla_pkg::quant(yla_pkg::INV_MICRO[i][j], F));
      end
    end
  end

  logic [NS:1] v_q;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v_q[NS] || pix_o.ready;
    for (int s = NS - 1; s >= 1; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign pix_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= pix_i.valid;
      end
      for (int s = 2; s <= NS; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // Stage 1: forward matrix products and luma fraction.
  logic signed [CB:0]   c_ext [3];
  logic signed [CW-1:0] k_d;
  logic signed [PW-1:0] s1_p_q [3][3];
  logic signed [CW-1:0] s1_k_q;

  assign c_ext[0] = signed'({1'b0, pix_i.red_in});
  assign c_ext[1] = signed'({1'b0, pix_i.green_in});
  assign c_ext[2] = signed'({1'b0, pix_i.blue_in});

  always_comb begin
    unique case (pix_i.level)
      yla_pkg::LVL_UP2: k_d = K_HI;
      yla_pkg::LVL_UP1: k_d = K_LO;
      yla_pkg::LVL_DN1: k_d = -K_LO;
      yla_pkg::LVL_DN2: k_d = -K_HI;
      yla_pkg::LVL_DN3: k_d = -K_MAX;
      default:          k_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[1] && pix_i.valid) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s1_p_q[i][j] <= PW'(fwd_c[i][j]) * PW'(c_ext[j]);
        end
      end
      s1_k_q <= k_d;
    end
  end

  // Stage 2: Y, I and Q sums.
  logic signed [YW-1:0] s2_yiq_q [3];
  logic signed [CW-1:0] s2_k_q;

  always_ff @(posedge clk_i) begin
    if (en[2] && v_q[1]) begin
      for (int i = 0; i < 3; i++) begin
        s2_yiq_q[i] <= YW'(s1_p_q[i][0] + s1_p_q[i][1] + s1_p_q[i][2]);
      end
      s2_k_q <= s1_k_q;
    end
  end

  // Stage 3: luma delta product.
  logic signed [MW-1:0] s3_m_q;
  logic signed [YW-1:0] s3_y_q;
  logic signed [YW-1:0] s3_i_q;
  logic signed [YW-1:0] s3_q_q;

  always_ff @(posedge clk_i) begin
    if (en[3] && v_q[2]) begin
      s3_m_q <= MW'(ONE - s2_yiq_q[0]) * MW'(s2_k_q);
      s3_y_q <= s2_yiq_q[0];
      s3_i_q <= s2_yiq_q[1];
      s3_q_q <= s2_yiq_q[2];
    end
  end

  // Stage 4: adjusted luma and inverse matrix products.
  logic signed [YW-1:0] s4_y_q;
  logic signed [PB-1:0] s4_p_q [3][2];

  always_ff @(posedge clk_i) begin
    if (en[4] && v_q[3]) begin
      s4_y_q <= YW'(s3_y_q + YW'((s3_m_q + HALF_F) >>> F));
      for (int i = 0; i < 3; i++) begin
        s4_p_q[i][0] <= PB'(inv_c[i][0]) * PB'(s3_i_q);
        s4_p_q[i][1] <= PB'(inv_c[i][1]) * PB'(s3_q_q);
      end
    end
  end

  // Stage 5: rounding, saturation and the output register.
  logic [CB-1:0] ch_d [3];
  logic [2:0]    clip_d;
  logic [CB-1:0] s5_ch_q [3];
  logic          s5_clip_q;

  for (genvar g = 0; g < 3; g++) begin : g_chan
    yla_chan_out #(
      .CHANNEL_BITS   (CB),
      .COEF_FRAC_BITS (F)
    ) u_chan (
      .y_i    (s4_y_q),
      .p_i_i  (s4_p_q[g][0]),
      .p_q_i  (s4_p_q[g][1]),
      .ch_o   (ch_d[g]),
      .clip_o (clip_d[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[5] && v_q[4]) begin
      for (int i = 0; i < 3; i++) begin
        s5_ch_q[i] <= ch_d[i];
      end
      s5_clip_q <= |clip_d;
    end
  end

  assign pix_o.valid     = v_q[NS];
  assign pix_o.red_out   = s5_ch_q[0];
  assign pix_o.green_out = s5_ch_q[1];
  assign pix_o.blue_out  = s5_ch_q[2];
  assign pix_o.clipped   = s5_clip_q;

endmodule

// ----- sv/yla_checker.sv -----
`timescale 1ns / 1ps
`include "yiq_luma_brightness_adjust_macros.svh"

module yla_checker #(
  parameter int CHANNEL_BITS = 8
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [CHANNEL_BITS-1:0] red_i,
  input logic [CHANNEL_BITS-1:0] green_i,
  input logic [CHANNEL_BITS-1:0] blue_i,
  input logic                    clipped_i
);

  localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

  logic [2:0] run_q;
  logic       in_acc;
  logic       edge_val;

  // Counts clock edges since reset was released, saturating.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (run_q != 3'd7) begin
      run_q <= run_q + 3'd1;
    end
  end

  assign in_acc  = in_valid_i && in_ready_i;
  assign edge_val = (red_i == '0) || (red_i == CH_MAX)
                 || (green_i == '0) || (green_i == CH_MAX)
                 || (blue_i == '0) || (blue_i == CH_MAX);

  `YLA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(red_i) && $stable(green_i) && $stable(blue_i)
    && $stable(clipped_i))
  `YLA_ASSERT_IMPLY(a_latency, clk_i, rst_ni,
    (run_q >= 3'd5) && $past(in_acc, 5) && $past(out_ready_i, 1)
    && $past(out_ready_i, 2) && $past(out_ready_i, 3) && $past(out_ready_i, 4),
    out_valid_i)
  `YLA_ASSERT_IMPLY(a_clip_edge, clk_i, rst_ni, out_valid_i && clipped_i, edge_val)

endmodule

bind yiq_luma_brightness_adjust yla_checker #(
  .CHANNEL_BITS (CHANNEL_BITS)
) u_yla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .red_i       (pix_o.red_out),
  .green_i     (pix_o.green_out),
  .blue_i      (pix_o.blue_out),
  .clipped_i   (pix_o.clipped)
);
